// ===== rtl/segmented_stack_with_pop_at_top_defines.svh =====
// ----------------------------------------------------------------------------
// Segmented stack assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_STACK_WITH_POP_AT_TOP_DEFINES_SVH
`define SEGMENTED_STACK_WITH_POP_AT_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is low.
`define SEGSTK_ASSERT_NOW(lbl, clk, rst_n, cond, resp, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (resp)) \
        else $error(msg);

// Next-cycle implication, masked while reset is low.
`define SEGSTK_ASSERT_NEXT(lbl, clk, rst_n, cond, resp, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (resp)) \
        else $error(msg);

`endif

// ===== rtl/segstk_pkg.sv =====
// ----------------------------------------------------------------------------
// Segmented stack package
// Field widths, opcodes, status codes and default sizes.
// ----------------------------------------------------------------------------
package segstk_pkg;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int CAP_W    = 5;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 40;   // value + index, padded to bytes
    localparam int M_TDATA_W = 32;

    localparam int DEF_NUM_SEGMENTS = 16;
    localparam int DEF_SEG_DEPTH    = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OPCODE_W-1:0] OP_PUSH     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP_LAST = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_AT   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE     = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_PUSHED  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_POPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DROPPED = 2'd3;

    localparam logic [VALUE_W-1:0] VAL_ZERO = '0;
    localparam logic [VALUE_W-1:0] VAL_NONE = '1;

endpackage

// ===== rtl/segmented_stack_with_pop_at_top.sv =====
// ----------------------------------------------------------------------------
// Segmented stack with pop at index
// Ordered row of bounded stacks kept in three synchronous memories.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+----------------------------------------
//  s_ (cmd)  | in  | s_tvalid/s_tready  | tuser: opcode; tdata: value, index
//  m_ (res)  | out | m_tvalid/m_tready  | tuser: status; tdata: pop value
//  cfg_      | in  | cfg_valid/cfg_ready| cfg_data: capacity
//
// One command in flight; a push or pop passes S_ORD and S_FILL before the result
// register loads; a push opening a segment behind a full one repeats them.
// A command answered without touching the stacks (zero capacity, empty, bad
// index, opcode three) goes to S_RESULT. A pop that empties a stack walks the
// order table over each later stack (S_SHIFT), then parks it at the end (S_TAIL).
// After reset the order and fill memories are swept with s_tready low; an m_
// stall holds the result load, after which a new command is taken while it waits.
//
`include "segmented_stack_with_pop_at_top_defines.svh"

module segmented_stack_with_pop_at_top
    import segstk_pkg::*;
#(
    parameter int NUM_SEGMENTS = DEF_NUM_SEGMENTS,
    parameter int SEG_DEPTH    = DEF_SEG_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] push_value, [35:32] segment_index
    input  logic [OPCODE_W-1:0]   s_tuser,   // [1:0] opcode

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] pop_value
    output logic [STATUS_W-1:0]   m_tuser,   // [1:0] status

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CAP_W-1:0]      cfg_data   // capacity
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int SW  = $clog2(NUM_SEGMENTS);              // segment index
    localparam int LW  = $clog2(NUM_SEGMENTS + 1);          // live count
    localparam int FW  = $clog2(SEG_DEPTH + 1);             // fill count
    localparam int AW  = $clog2(NUM_SEGMENTS * SEG_DEPTH);  // element address
    localparam int EW  = (FW > CAP_W) ? FW : CAP_W;         // capacity compare
    localparam int CW  = (LW > INDEX_W) ? LW : INDEX_W;     // index compare
    localparam int NUM_ELEMS = NUM_SEGMENTS * SEG_DEPTH;

    // Sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;  // reset sweep of order/fill
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ORD    = 3'd2;  // order data back, read fill
    localparam logic [2:0] S_FILL   = 3'd3;  // fill data back, decide
    localparam logic [2:0] S_SHIFT  = 3'd4;  // close up the order table
    localparam logic [2:0] S_TAIL   = 3'd5;  // park emptied segment at end
    localparam logic [2:0] S_RESULT = 3'd6;

    // ------------------------------------------------------------------
    // Control and payload registers
    // ------------------------------------------------------------------
    logic [2:0]          state_reg, state_next;
    logic [SW-1:0]       clr_reg, clr_next;
    logic [LW-1:0]       live_reg, live_next;
    logic [CAP_W-1:0]    cap_reg;
    logic                m_tvalid_reg, m_tvalid_next;

    logic                is_push_reg, is_push_next;
    logic                new_done_reg, new_done_next;
    logic [SW-1:0]       log_reg, log_next;      // logical stack being worked
    logic [SW-1:0]       p_reg, p_next;          // its physical segment
    logic [SW-1:0]       rd_idx_reg, rd_idx_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [VALUE_W-1:0]  res_val_reg, res_val_next;
    logic [STATUS_W-1:0] res_stat_reg, res_stat_next;
    logic                sel_store_reg, sel_store_next;
    logic [VALUE_W-1:0]  m_value_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic                m_load;

    // ------------------------------------------------------------------
    // Memories: order table, fill counts, element store
    // ------------------------------------------------------------------
    logic [SW-1:0]       order_mem [NUM_SEGMENTS];
    logic                ord_we, ord_re;
    logic [SW-1:0]       ord_waddr, ord_raddr, ord_wdata, ord_rdata_reg;

    logic [FW-1:0]       fill_mem [NUM_SEGMENTS];
    logic                fill_we, fill_re;
    logic [SW-1:0]       fill_waddr, fill_raddr;
    logic [FW-1:0]       fill_wdata, fill_rdata_reg;

    logic [VALUE_W-1:0]  store_mem [NUM_ELEMS];
    logic                st_we, st_re;
    logic [AW-1:0]       st_waddr, st_raddr;
    logic [VALUE_W-1:0]  st_rdata_reg;

    // Accesses in one cycle never hit the same entry of one memory
    // (the walk writes i-1 while reading i+1), so no bypass is needed.
    always_ff @(posedge aclk) begin
        if (ord_we) begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        if (ord_re) begin
            ord_rdata_reg <= order_mem[ord_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (fill_re) begin
            fill_rdata_reg <= fill_mem[fill_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= val_reg;
        end
        if (st_re) begin
            st_rdata_reg <= store_mem[st_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Input fields and derived conditions
    // ------------------------------------------------------------------
    logic [OPCODE_W-1:0] in_op;
    logic [VALUE_W-1:0]  in_val;
    logic [INDEX_W-1:0]  in_idx;
    logic [EW-1:0]       cap_eff;
    logic                cap_zero, live_zero, idx_ok;

    assign in_op  = s_tuser;
    assign in_val = s_tdata[VALUE_W-1:0];
    assign in_idx = s_tdata[VALUE_W +: INDEX_W];

    // Capacity saturates at the segment depth.
    assign cap_eff   = (EW'(cap_reg) > EW'(SEG_DEPTH)) ? EW'(SEG_DEPTH) : EW'(cap_reg);
    assign cap_zero  = (cap_eff == '0);
    assign live_zero = (live_reg == '0);
    assign idx_ok    = (CW'(in_idx) < CW'(live_reg));

    function automatic logic [AW-1:0] elem_addr(input logic [SW-1:0] seg,
                                                input logic [FW-1:0] pos);
        return AW'(seg) * AW'(SEG_DEPTH) + AW'(pos);
    endfunction

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        live_next      = live_reg;
        is_push_next   = is_push_reg;
        new_done_next  = new_done_reg;
        log_next       = log_reg;
        p_next         = p_reg;
        rd_idx_next    = rd_idx_reg;
        val_next       = val_reg;
        res_val_next   = res_val_reg;
        res_stat_next  = res_stat_reg;
        sel_store_next = sel_store_reg;
        m_load         = 1'b0;

        ord_we     = 1'b0;
        ord_waddr  = '0;
        ord_wdata  = '0;
        ord_re     = 1'b0;
        ord_raddr  = '0;
        fill_we    = 1'b0;
        fill_waddr = '0;
        fill_wdata = '0;
        fill_re    = 1'b0;
        fill_raddr = '0;
        st_we      = 1'b0;
        st_waddr   = '0;
        st_re      = 1'b0;
        st_raddr   = '0;

        unique case (state_reg)
            S_CLEAR: begin
                // identity order, empty segments
                ord_we     = 1'b1;
                ord_waddr  = clr_reg;
                ord_wdata  = clr_reg;
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                fill_wdata = '0;
                if (clr_reg == SW'(NUM_SEGMENTS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE: begin
                if (s_tvalid) begin
                    val_next       = in_val;
                    is_push_next   = (in_op == OP_PUSH);
                    sel_store_next = 1'b0;
                    res_val_next   = VAL_NONE;
                    res_stat_next  = STAT_EMPTY;
                    state_next     = S_RESULT;
                    unique case (in_op)
                        OP_PUSH: begin
                            res_val_next  = VAL_ZERO;
                            res_stat_next = STAT_DROPPED;
                            if (!cap_zero) begin
                                state_next = S_ORD;
                                ord_re     = 1'b1;
                                if (live_zero) begin
                                    // first stack opens at once
                                    live_next     = LW'(1);
                                    new_done_next = 1'b1;
                                    log_next      = '0;
                                    ord_raddr     = '0;
                                end else begin
                                    new_done_next = 1'b0;
                                    log_next      = SW'(live_reg - 1'b1);
                                    ord_raddr     = SW'(live_reg - 1'b1);
                                end
                            end
                        end
                        OP_POP_LAST: begin
                            if (!cap_zero && !live_zero) begin
                                state_next = S_ORD;
                                log_next   = SW'(live_reg - 1'b1);
                                ord_re     = 1'b1;
                                ord_raddr  = SW'(live_reg - 1'b1);
                            end
                        end
                        OP_POP_AT: begin
                            if (!cap_zero && idx_ok) begin
                                state_next = S_ORD;
                                log_next   = SW'(in_idx);
                                ord_re     = 1'b1;
                                ord_raddr  = SW'(in_idx);
                            end
                        end
                        OP_NONE: begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_ORD: begin
                p_next     = ord_rdata_reg;
                fill_re    = 1'b1;
                fill_raddr = ord_rdata_reg;
                state_next = S_FILL;
            end

            S_FILL: begin
                if (is_push_reg) begin
                    if (!new_done_reg && (EW'(fill_rdata_reg) >= cap_eff)) begin
                        if (live_reg >= LW'(NUM_SEGMENTS)) begin
                            res_val_next  = VAL_ZERO;
                            res_stat_next = STAT_DROPPED;
                            state_next    = S_RESULT;
                        end else begin
                            // last stack full: open the next one
                            live_next     = live_reg + 1'b1;
                            log_next      = SW'(live_reg);
                            new_done_next = 1'b1;
                            ord_re        = 1'b1;
                            ord_raddr     = SW'(live_reg);
                            state_next    = S_ORD;
                        end
                    end else if (fill_rdata_reg < FW'(SEG_DEPTH)) begin
                        st_we         = 1'b1;
                        st_waddr      = elem_addr(p_reg, fill_rdata_reg);
                        fill_we       = 1'b1;
                        fill_waddr    = p_reg;
                        fill_wdata    = fill_rdata_reg + 1'b1;
                        res_val_next  = VAL_ZERO;
                        res_stat_next = STAT_PUSHED;
                        state_next    = S_RESULT;
                    end else begin
                        res_val_next  = VAL_ZERO;
                        res_stat_next = STAT_DROPPED;
                        state_next    = S_RESULT;
                    end
                end else begin
                    res_stat_next = STAT_POPPED;
                    if (fill_rdata_reg != '0) begin
                        st_re          = 1'b1;
                        st_raddr       = elem_addr(p_reg, fill_rdata_reg - 1'b1);
                        fill_we        = 1'b1;
                        fill_waddr     = p_reg;
                        fill_wdata     = fill_rdata_reg - 1'b1;
                        sel_store_next = 1'b1;
                    end else begin
                        res_val_next   = VAL_ZERO;
                        sel_store_next = 1'b0;
                    end
                    if (fill_rdata_reg <= FW'(1)) begin
                        // stack now empty: remove it from the order
                        if ((LW'(log_reg) + LW'(1)) < live_reg) begin
                            ord_re      = 1'b1;
                            ord_raddr   = SW'(log_reg + 1'b1);
                            rd_idx_next = SW'(log_reg + 1'b1);
                            state_next  = S_SHIFT;
                        end else begin
                            state_next = S_TAIL;
                        end
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end

            S_SHIFT: begin
                ord_we    = 1'b1;
                ord_waddr = rd_idx_reg - 1'b1;
                ord_wdata = ord_rdata_reg;
                if ((LW'(rd_idx_reg) + LW'(1)) < live_reg) begin
                    ord_re      = 1'b1;
                    ord_raddr   = rd_idx_reg + 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end else begin
                    state_next = S_TAIL;
                end
            end

            S_TAIL: begin
                ord_we     = 1'b1;
                ord_waddr  = SW'(live_reg - 1'b1);
                ord_wdata  = p_reg;
                live_next  = live_reg - 1'b1;
                state_next = S_RESULT;
            end

            S_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_load     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (m_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            live_reg     <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            live_reg     <= live_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        is_push_reg   <= is_push_next;
        new_done_reg  <= new_done_next;
        log_reg       <= log_next;
        p_reg         <= p_next;
        rd_idx_reg    <= rd_idx_next;
        val_reg       <= val_next;
        res_val_reg   <= res_val_next;
        res_stat_reg  <= res_stat_next;
        sel_store_reg <= sel_store_next;
        if (m_load) begin
            m_value_reg  <= sel_store_reg ? st_rdata_reg : res_val_reg;
            m_status_reg <= res_stat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SEGSTK_ASSERT_NOW(a_live_bound, aclk, aresetn, 1'b1,
        live_reg <= LW'(NUM_SEGMENTS), "live stack count above segment count")

    `SEGSTK_ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        (state_reg == S_RESULT) && (!m_tvalid_reg || m_tready),
        m_tvalid_reg && (state_reg == S_IDLE), "result not presented after load")

    `SEGSTK_ASSERT_NEXT(a_tail_drops_one, aclk, aresetn, state_reg == S_TAIL,
        live_reg == ($past(live_reg) - 1'b1), "emptied stack not removed")

    `SEGSTK_ASSERT_NOW(a_push_zero, aclk, aresetn,
        m_tvalid_reg && ((m_status_reg == STAT_PUSHED) || (m_status_reg == STAT_DROPPED)),
        m_value_reg == VAL_ZERO, "push result carries nonzero value")

endmodule
